// ----- rtl/base64_stream_decoder_assert.svh -----
// Assertion macros for the decoder's RTL, used by b64sd_core.sv.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define B64SD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define B64SD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define B64SD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/b64sd_pkg.sv -----
`timescale 1ns / 1ps

package b64sd_pkg;

   // ASCII codes that the character classifier tests against.
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;

   // Offsets of the lower-case letters and digits within the alphabet.
   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;

   localparam logic [5:0] SEXTET_62 = 6'd62;
   localparam logic [5:0] SEXTET_63 = 6'd63;

   typedef enum logic [1:0] {
      KIND_SEXTET,
      KIND_PAD,
      KIND_BLANK,
      KIND_BAD
   } char_kind_type;

   typedef struct packed {
      char_kind_type kind;
      logic [5:0]    sextet;
   } char_class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_run;
      logic       invalid_input;
   } rsp_payload_type;

endpackage

// ----- rtl/b64sd_channels.sv -----
`timescale 1ns / 1ps

// Character channel into the decoder.
interface b64sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_string;

   modport source (output valid, char_code, end_of_string, input ready);
   modport sink   (input valid, char_code, end_of_string, output ready);
endinterface

// Result channel out of the decoder.
interface b64sd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_run;
   logic       invalid_input;

   modport source (output valid, data_byte, byte_valid, end_of_run, invalid_input,
                   input ready);
   modport sink   (input valid, data_byte, byte_valid, end_of_run, invalid_input,
                   output ready);
endinterface

// ----- rtl/b64sd_char_class.sv -----
`timescale 1ns / 1ps

// Sorts one ASCII character into alphabet, pad, blank or invalid, and gives
// its six-bit value when it belongs to the alphabet.
module b64sd_char_class (
   input  logic [7:0]               char_code,
   output b64sd_pkg::char_class_type char_class
);
   import b64sd_pkg::*;

   always_comb begin
      char_class.kind   = KIND_BAD;
      char_class.sextet = 6'd0;
      if (char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         char_class.kind   = KIND_SEXTET;
         char_class.sextet = 6'(char_code - CHAR_UPPER_A);
      end else if (char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         char_class.kind   = KIND_SEXTET;
         char_class.sextet = 6'(char_code - CHAR_LOWER_A + LOWER_BASE);
      end else if (char_code inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
         char_class.kind   = KIND_SEXTET;
         char_class.sextet = 6'(char_code - CHAR_DIGIT_0 + DIGIT_BASE);
      end else if (char_code inside {CHAR_PLUS, CHAR_MINUS}) begin
         char_class.kind   = KIND_SEXTET;
         char_class.sextet = SEXTET_62;
      end else if (char_code inside {CHAR_SLASH, CHAR_UNDER}) begin
         char_class.kind   = KIND_SEXTET;
         char_class.sextet = SEXTET_63;
      end else if (char_code == CHAR_EQUALS) begin
         char_class.kind = KIND_PAD;
      end else if (char_code inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF}) begin
         char_class.kind = KIND_BLANK;
      end
   end

endmodule

// ----- rtl/b64sd_core.sv -----
`timescale 1ns / 1ps
`include "base64_stream_decoder_assert.svh"

// Input register, decode state and the combinational step that joins a new
// sextet to the pending bits.
module b64sd_core (
   input  logic                       clock,
   input  logic                       reset,
   b64sd_req_if.sink                  req_chan,
   output logic                       res_valid,
   input  logic                       res_ready,
   output b64sd_pkg::rsp_payload_type res_payload
);
   import b64sd_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     s1_char_ff;
   logic           s1_eos_ff;
   logic [5:0]     residual_bits_ff, residual_bits_in;
   logic [2:0]     residual_count_ff, residual_count_in;
   logic           pad_seen_ff, pad_seen_in;
   logic           error_seen_ff, error_seen_in;

   char_class_type char_class;
   logic           active;
   logic           take_sextet;
   logic [11:0]    acc;
   logic [7:0]     byte_value;
   logic           have_byte;
   logic [5:0]     step_bits;
   logic [2:0]     step_count;
   logic           error_after;
   logic           makes_result;
   logic           s1_advance;
   logic           req_fire;

   b64sd_char_class u_char_class (
      .char_code  (s1_char_ff),
      .char_class (char_class)
   );

   assign active      = !pad_seen_ff && !error_seen_ff;
   assign take_sextet = active && (char_class.kind == KIND_SEXTET);
   assign acc         = {residual_bits_ff, char_class.sextet};

   // Six new bits complete a byte unless nothing was pending.
   always_comb begin
      case (residual_count_ff[2:1])
         2'd1: begin
            byte_value = acc[7:0];
            have_byte  = take_sextet;
            step_bits  = 6'd0;
            step_count = 3'd0;
         end
         2'd2: begin
            byte_value = acc[9:2];
            have_byte  = take_sextet;
            step_bits  = {4'd0, acc[1:0]};
            step_count = 3'd2;
         end
         2'd3: begin
            byte_value = acc[11:4];
            have_byte  = take_sextet;
            step_bits  = {2'd0, acc[3:0]};
            step_count = 3'd4;
         end
         default: begin
            byte_value = 8'd0;
            have_byte  = 1'b0;
            step_bits  = char_class.sextet;
            step_count = 3'd6;
         end
      endcase
   end

   assign error_after  = error_seen_ff || (active && char_class.kind == KIND_BAD);
   assign makes_result = s1_eos_ff || have_byte;
   assign s1_advance   = s1_valid_ff && (!makes_result || res_ready);
   assign req_fire     = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || s1_advance;

   assign res_valid                 = s1_valid_ff && makes_result;
   assign res_payload.data_byte     = have_byte ? byte_value : 8'd0;
   assign res_payload.byte_valid    = have_byte;
   assign res_payload.end_of_run    = s1_eos_ff;
   assign res_payload.invalid_input = s1_eos_ff && error_after;

   always_comb begin
      s1_valid_in       = req_fire || (s1_valid_ff && !s1_advance);
      residual_bits_in  = residual_bits_ff;
      residual_count_in = residual_count_ff;
      pad_seen_in       = pad_seen_ff;
      error_seen_in     = error_seen_ff;
      if (s1_advance) begin
         if (s1_eos_ff) begin
            residual_bits_in  = 6'd0;
            residual_count_in = 3'd0;
            pad_seen_in       = 1'b0;
            error_seen_in     = 1'b0;
         end else begin
            if (take_sextet) begin
               residual_bits_in  = step_bits;
               residual_count_in = step_count;
            end
            pad_seen_in   = pad_seen_ff || (active && char_class.kind == KIND_PAD);
            error_seen_in = error_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         residual_bits_ff  <= 6'd0;
         residual_count_ff <= 3'd0;
         pad_seen_ff       <= 1'b0;
         error_seen_ff     <= 1'b0;
      end else begin
         s1_valid_ff       <= s1_valid_in;
         residual_bits_ff  <= residual_bits_in;
         residual_count_ff <= residual_count_in;
         pad_seen_ff       <= pad_seen_in;
         error_seen_ff     <= error_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_char_ff <= req_chan.char_code;
         s1_eos_ff  <= req_chan.end_of_string;
      end
   end

   `B64SD_ASSERT_ALWAYS(a_count_even, residual_count_ff[0] == 1'b0, "odd residual count")
   `B64SD_ASSERT_ALWAYS(a_pad_error_excl, !(pad_seen_ff && error_seen_ff), "pad and error both set")
   `B64SD_ASSERT_NEXT(a_clear_after_end, s1_advance && s1_eos_ff,
      residual_count_ff == 3'd0 && !pad_seen_ff && !error_seen_ff, "state not cleared at end")
   `B64SD_ASSERT_SAME(a_empty_result_ends, res_valid && !res_payload.byte_valid,
      res_payload.end_of_run, "result without byte or end mark")

endmodule

// ----- rtl/b64sd_out_reg.sv -----
`timescale 1ns / 1ps

// Result register: holds one finished result until the consumer takes it and
// can reload in the cycle that it is taken.
module b64sd_out_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       res_valid,
   output logic                       res_ready,
   input  b64sd_pkg::rsp_payload_type res_payload,
   b64sd_rsp_if.source                rsp_chan
);
   import b64sd_pkg::*;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_payload_ff;
   logic            load;

   assign res_ready    = !out_valid_ff || rsp_chan.ready;
   assign load         = res_valid && res_ready;
   assign out_valid_in = load || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_payload_ff <= res_payload;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.data_byte     = out_payload_ff.data_byte;
   assign rsp_chan.byte_valid    = out_payload_ff.byte_valid;
   assign rsp_chan.end_of_run    = out_payload_ff.end_of_run;
   assign rsp_chan.invalid_input = out_payload_ff.invalid_input;

endmodule

// ----- rtl/base64_stream_decoder.sv -----
`timescale 1ns / 1ps

// Channel    Role    Payload
// req_chan   sink    char_code[7:0], end_of_string
// rsp_chan   source  data_byte[7:0], byte_valid, end_of_run, invalid_input
//
// Each character is held in the input register, where it is classified and joined
// to the pending bits; its result, if any, then moves into the result register.
// One character is taken per cycle unless req_chan stalls; a result goes through the input
// register, then the result register. Synchronous reset clears the pending bits, the pad
// and error flags and both valid flags. A stall on rsp_chan holds the result register;
// characters with no result still pass, and req_chan stops only when a result finds it full.

module base64_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   b64sd_req_if.sink   req_chan,
   b64sd_rsp_if.source rsp_chan
);
   import b64sd_pkg::*;

   // Result handed from the decode stage to the result register.
   logic            res_valid;
   logic            res_ready;
   rsp_payload_type res_payload;

   // Decode stage: input register, decode state and the per-character step.
   b64sd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload)
   );

   // Result register, which decouples the consumer's stalls from the decoder.
   b64sd_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ----- tb/tb_base64_stream_decoder.sv -----
`timescale 1ns / 1ps

module tb_base64_stream_decoder;
   import b64sd_pkg::*;

   // Stream length, counting the directed strings, from which no further string is started.
   localparam int unsigned TOTAL_CHARS   = 950;
   // Points in the stream where the two pressure episodes are started.
   localparam int unsigned HOLD_AT_CHAR  = 300;
   localparam int unsigned PAUSE_AT_CHAR = 600;
   // Idling is switched off for a middle stretch and for the closing part.
   localparam int unsigned QUIET_FROM    = 420;
   localparam int unsigned QUIET_TO      = 520;
   localparam int unsigned CALM_FROM     = 800;
   // The result channel is held off for this many cycles during the long stall.
   localparam int unsigned LONG_HOLD     = 200;
   // Idle cycles allowed after the last awaited result before the run ends.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Cycles without any transfer on either channel before the run is abandoned.
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned REPORT_LIMIT  = 10;

   // The checker holds its own copy of the decoder state and predicts what each
   // accepted character must produce. Predictions queue up in arrival order.
   class decoded_stream_checker;
      logic [5:0]      pending_bits;
      logic [2:0]      pending_count;
      bit              pad_flag;
      bit              error_flag;
      rsp_payload_type awaited_results[$];
      int unsigned     failure_count;

      function new();
         clear_run();
         failure_count = 0;
      endfunction

      function void clear_run();
         pending_bits  = '0;
         pending_count = '0;
         pad_flag      = 1'b0;
         error_flag    = 1'b0;
      endfunction

      // Maps an alphabet character onto its six-bit value; returns 0 for
      // anything outside the alphabet.
      function bit sextet_value(input logic [7:0] c, output logic [5:0] v);
         v = '0;
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) v = 6'(c - CHAR_UPPER_A);
         else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) v = 6'(c - CHAR_LOWER_A + LOWER_BASE);
         else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) v = 6'(c - CHAR_DIGIT_0 + DIGIT_BASE);
         else if (c == CHAR_PLUS || c == CHAR_MINUS) v = SEXTET_62;
         else if (c == CHAR_SLASH || c == CHAR_UNDER) v = SEXTET_63;
         else return 1'b0;
         return 1'b1;
      endfunction

      function void note_char(input logic [7:0] c, input logic last);
         logic [5:0]  v;
         logic [11:0] joined;
         int unsigned total;
         int unsigned rest;
         logic [7:0]  byte_out;
         bit          have_byte;
         byte_out  = '0;
         have_byte = 1'b0;
         // After a pad or an error the rest of the string is ignored.
         if (!pad_flag && !error_flag) begin
            if (c == CHAR_EQUALS) begin
               pad_flag = 1'b1;
            end else if (sextet_value(c, v)) begin
               joined = {pending_bits, v};
               total  = pending_count + 6;
               if (total >= 8) begin
                  rest          = total - 8;
                  byte_out      = 8'(joined >> rest);
                  have_byte     = 1'b1;
                  pending_bits  = 6'(joined & ((12'd1 << rest) - 12'd1));
                  pending_count = 3'(rest);
               end else begin
                  pending_bits  = joined[5:0];
                  pending_count = 3'(total);
               end
            end else if (!(c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF)) begin
               error_flag = 1'b1;
            end
         end
         // The last character always closes the run; leftover bits are dropped.
         if (last) begin
            awaited_results.push_back({byte_out, have_byte, 1'b1, error_flag});
            clear_run();
         end else if (have_byte) begin
            awaited_results.push_back({byte_out, 1'b1, 1'b0, 1'b0});
         end
      endfunction

      function void note_failure(input string msg);
         failure_count++;
         if (failure_count <= REPORT_LIMIT) $display("%t mismatch: %s", $realtime, msg);
      endfunction

      function void check_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_results.size() == 0) begin
            note_failure($sformatf("unexpected result byte %02h valid %0b end %0b invalid %0b",
                                   got.data_byte, got.byte_valid, got.end_of_run,
                                   got.invalid_input));
            return;
         end
         want = awaited_results.pop_front();
         if (got.data_byte != want.data_byte || got.byte_valid != want.byte_valid ||
             got.end_of_run != want.end_of_run || got.invalid_input != want.invalid_input) begin
            note_failure($sformatf({"expected byte %02h valid %0b end %0b invalid %0b, ",
                                    "got byte %02h valid %0b end %0b invalid %0b"},
                                   want.data_byte, want.byte_valid, want.end_of_run,
                                   want.invalid_input, got.data_byte, got.byte_valid,
                                   got.end_of_run, got.invalid_input));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   b64sd_req_if req ();
   b64sd_rsp_if rsp ();

   base64_stream_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   decoded_stream_checker checker_h;

   // Shared between the sender and the receiver: whether idle bursts are
   // allowed at present, and a request for the long hold-off on the result side.
   bit          gaps_on;
   bit          long_hold_request;
   int unsigned chars_sent;
   logic [7:0]  run_chars[$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Both channels are sampled at the rising edge, before any register of the
   // block or of the bench has taken its new value, so a transfer is seen
   // exactly when valid and ready were both high going into the edge. The
   // character is noted before the result is checked, so a result can never be
   // compared ahead of the character that caused it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) checker_h.note_char(req.char_code, req.end_of_string);
         if (rsp.valid && rsp.ready)
            checker_h.check_result({rsp.data_byte, rsp.byte_valid, rsp.end_of_run,
                                    rsp.invalid_input});
      end
   end

   // The watchdog runs out only if neither channel moves for a long while, which
   // covers a hung handshake as well as results that never turn up.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // Result side. Ready drops in short random bursts while idling is allowed,
   // and once for a long stretch on request so that the block backs up and has
   // to stall its input.
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         if (long_hold_request) begin
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_request = 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offers one character and returns at the edge where it is taken. Valid is
   // only lowered for an idle burst, so back-to-back characters keep it high.
   task send_char(input logic [7:0] c, input logic last);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.char_code     <= c;
      req.end_of_string <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      chars_sent++;
   endtask

   // Sends the characters collected in run_chars as one string.
   task send_run();
      for (int i = 0; i < run_chars.size(); i++) send_char(run_chars[i], i == run_chars.size() - 1);
   endtask

   task send_text(input string s);
      run_chars.delete();
      for (int i = 0; i < s.len(); i++) run_chars.push_back(s.getc(i));
      send_run();
   endtask

   // Stops offering characters until every predicted result has come back,
   // then lets the pipeline settle.
   task wait_for_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (checker_h.awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Either alphabet spelling of 62 and 63 is picked at random.
   function logic [7:0] char_for_sextet(input logic [5:0] v);
      if (v < LOWER_BASE) return 8'(CHAR_UPPER_A + v);
      if (v < DIGIT_BASE) return 8'(CHAR_LOWER_A + v - LOWER_BASE);
      if (v < SEXTET_62) return 8'(CHAR_DIGIT_0 + v - DIGIT_BASE);
      if (v == SEXTET_62) return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      return $urandom_range(0, 1) ? CHAR_SLASH : CHAR_UNDER;
   endfunction

   function logic [7:0] random_blank();
      case ($urandom_range(0, 3))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // Adds one alphabet character, now and then preceded by whitespace.
   task add_sextet_char();
      if ($urandom_range(0, 9) == 0) run_chars.push_back(random_blank());
      run_chars.push_back(char_for_sextet(6'($urandom_range(0, 63))));
   endtask

   // A properly formed string of four-character groups, the last one possibly
   // padded with one or two '=' signs.
   task build_well_formed();
      int unsigned groups;
      int unsigned data_chars;
      groups = $urandom_range(1, 6);
      for (int g = 0; g < groups; g++) begin
         data_chars = (g == groups - 1 && $urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 4;
         repeat (data_chars) add_sextet_char();
         repeat (4 - data_chars) run_chars.push_back(CHAR_EQUALS);
      end
   endtask

   task build_random_run();
      int unsigned kind;
      int unsigned pos;
      run_chars.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         build_well_formed();
      end else if (kind == 7) begin
         // A good string spoilt by one arbitrary code somewhere inside it.
         build_well_formed();
         pos = $urandom_range(0, run_chars.size());
         run_chars.insert(pos, 8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 8)) run_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
         // Unpadded lengths can leave bits over at the end of the string.
         repeat ($urandom_range(1, 12)) add_sextet_char();
      end
   endtask

   initial begin
      bit hold_done;
      bit pause_done;
      checker_h         = new();
      gaps_on           = 1'b1;
      long_hold_request = 1'b0;
      chars_sent        = 0;
      hold_done         = 1'b0;
      pause_done        = 1'b0;
      reset             <= 1'b1;
      req.valid         <= 1'b0;
      req.char_code     <= '0;
      req.end_of_string <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed strings. Three full bytes with the last one on the final
      // character, then the extra alphabet symbols alongside the standard ones.
      send_text("TWFu");
      send_text("-_+/");
      // Padding stops decoding, so the later bad character goes unnoticed and
      // the leftover bits of "Q" are dropped.
      send_text("QQ=*");
      // Whitespace inside a string is skipped.
      send_text("a\t\r\n9");
      // A zero code is an error; everything after it, even code 255, is ignored,
      // and the error is reported on the closing result.
      run_chars.delete();
      run_chars.push_back(CHAR_UPPER_A);
      run_chars.push_back(8'h00);
      run_chars.push_back(8'hFF);
      run_chars.push_back(CHAR_LOWER_Z);
      send_run();
      // One-character strings: a lone pad and a lone error on the last character.
      run_chars.delete();
      run_chars.push_back(CHAR_EQUALS);
      send_run();
      run_chars.delete();
      run_chars.push_back(8'hFF);
      send_run();

      while (chars_sent < TOTAL_CHARS) begin
         gaps_on = !((chars_sent >= QUIET_FROM && chars_sent < QUIET_TO) ||
                     chars_sent >= CALM_FROM);
         if (!hold_done && chars_sent >= HOLD_AT_CHAR) begin
            long_hold_request = 1'b1;
            hold_done         = 1'b1;
         end
         if (!pause_done && chars_sent >= PAUSE_AT_CHAR) begin
            wait_for_results();
            pause_done = 1'b1;
         end
         build_random_run();
         send_run();
      end

      wait_for_results();
      if (checker_h.failure_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/b64sd_pkg.sv
rtl/b64sd_channels.sv
rtl/b64sd_char_class.sv
rtl/b64sd_core.sv
rtl/b64sd_out_reg.sv
rtl/base64_stream_decoder.sv
tb/tb_base64_stream_decoder.sv
